FILE: rtl/core/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
package bba_pkg;

    localparam int REG_W     = 13;
    localparam int BLK_W     = 12;
    localparam int CFG_IDX_W = 8;

    localparam logic [REG_W-1:0] FIRST_RESET = 13'd16;
    localparam logic [REG_W-1:0] LIMIT_RESET = 13'd4088;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 8'd1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_RANGE        = 2'd1;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd2;
    localparam logic [1:0] ST_FULL         = 2'd3;

    // status of the word in the last stage of the first-free finder
    typedef struct packed {
        logic valid;
        logic hit;
        logic last;
    } bba_find_t;

endpackage

FILE: rtl/core/bba_bitmap_store.sv
// Bitmap memory: one wide word per row, registered read, init sweep after reset.
module bba_bitmap_store import bba_pkg::*; #(
    parameter int BLOCK_COUNT = 4096,
    parameter int WB          = 256,
    parameter int AW          = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [WB-1:0] wr_data,
    output logic          rd_valid,
    output logic [AW-1:0] rd_addr_q,
    output logic [WB-1:0] rd_data,
    output logic          init_busy
);

    localparam int WBB        = $clog2(WB);
    localparam int WORDS      = (BLOCK_COUNT + WB - 1) / WB;
    localparam int IW         = AW + WBB + 1;
    localparam int INIT_END_I = (int'(LIMIT_RESET) < BLOCK_COUNT) ? int'(LIMIT_RESET)
                                                                   : BLOCK_COUNT;
    localparam logic [IW-1:0] INIT_FIRST = IW'(FIRST_RESET);
    localparam logic [IW-1:0] INIT_END   = IW'(INIT_END_I);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(WORDS - 1);

    logic [WB-1:0] mem [WORDS];

    logic          busy_reg, busy_next;
    logic [AW-1:0] init_addr_reg, init_addr_next;
    logic          rd_valid_reg;
    logic [AW-1:0] rd_addr_reg;
    logic [WB-1:0] rd_data_reg;
    logic [WB-1:0] init_word;

    // reset image: data region free, reserved blocks used
    always_comb begin
        for (int i = 0; i < WB; i++) begin
            init_word[i] = ({1'b0, init_addr_reg, WBB'(i)} >= INIT_FIRST) &&
                           ({1'b0, init_addr_reg, WBB'(i)} <  INIT_END);
        end
    end

    always_comb begin
        busy_next      = busy_reg;
        init_addr_next = init_addr_reg;
        if (busy_reg) begin
            init_addr_next = init_addr_reg + AW'(1);
            if (init_addr_reg == LAST_ADDR) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b1;
            init_addr_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            busy_reg      <= busy_next;
            init_addr_reg <= init_addr_next;
            rd_valid_reg  <= rd_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            mem[init_addr_reg] <= init_word;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    assign rd_valid  = rd_valid_reg;
    assign rd_addr_q = rd_addr_reg;
    assign rd_data   = rd_data_reg;
    assign init_busy = busy_reg;

endmodule

FILE: rtl/core/bba_first_free.sv
// Pipelined lowest-free-bit finder over streamed bitmap words.
module bba_first_free import bba_pkg::*; #(
    parameter int WB = 256,
    parameter int AW = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   flush,
    input  logic                   in_valid,
    input  logic [AW-1:0]          in_addr,
    input  logic [WB-1:0]          in_data,
    input  logic [AW-1:0]          start_word,
    input  logic [AW-1:0]          last_word,
    input  logic [WB-1:0]          lo_mask,
    input  logic [WB-1:0]          hi_mask,
    output bba_find_t              find,
    output logic [AW-1:0]          hit_addr,
    output logic [$clog2(WB)-1:0]  hit_bit,
    output logic [WB-1:0]          hit_word
);

    localparam int WBB = $clog2(WB);
    localparam int NG  = WB / 8;
    localparam int NS  = WB / 64;

    // stage 1: region mask and 8-bit group encode
    logic [WB-1:0] masked;
    logic [NG-1:0] grp_nz;
    logic [2:0]    grp_idx [NG];

    logic          s1_valid_reg;
    logic          s1_last_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [WB-1:0] s1_word_reg;
    logic [NG-1:0] s1_nz_reg;
    logic [2:0]    s1_idx_reg [NG];

    // stage 2: 64-bit super-group encode
    logic [NS-1:0] sup_nz;
    logic [5:0]    sup_idx [NS];

    logic          s2_valid_reg;
    logic          s2_last_reg;
    logic [AW-1:0] s2_addr_reg;
    logic [WB-1:0] s2_word_reg;
    logic [NS-1:0] s2_nz_reg;
    logic [5:0]    s2_idx_reg [NS];

    logic           hit;
    logic [WBB-1:0] bit_sel;

    always_comb begin
        masked = in_data;
        if (in_addr == start_word) begin
            masked = masked & lo_mask;
        end
        if (in_addr == last_word) begin
            masked = masked & hi_mask;
        end
        for (int g = 0; g < NG; g++) begin
            grp_nz[g]  = |masked[g*8 +: 8];
            grp_idx[g] = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (masked[g*8 + j]) begin
                    grp_idx[g] = 3'(j);
                end
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            sup_nz[s]  = 1'b0;
            sup_idx[s] = 6'd0;
            for (int k = 7; k >= 0; k--) begin
                if (s1_nz_reg[s*8 + k]) begin
                    sup_nz[s]  = 1'b1;
                    sup_idx[s] = {3'(k), s1_idx_reg[s*8 + k]};
                end
            end
        end
    end

    always_comb begin
        hit     = 1'b0;
        bit_sel = '0;
        for (int s = NS - 1; s >= 0; s--) begin
            if (s2_nz_reg[s]) begin
                hit     = 1'b1;
                bit_sel = WBB'(s * 64) | WBB'(s2_idx_reg[s]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid && !flush;
            s2_valid_reg <= s1_valid_reg && !flush;
        end
    end

    always_ff @(posedge aclk) begin
        s1_last_reg <= (in_addr == last_word);
        s1_addr_reg <= in_addr;
        s1_word_reg <= in_data;
        s1_nz_reg   <= grp_nz;
        for (int g = 0; g < NG; g++) begin
            s1_idx_reg[g] <= grp_idx[g];
        end
        s2_last_reg <= s1_last_reg;
        s2_addr_reg <= s1_addr_reg;
        s2_word_reg <= s1_word_reg;
        s2_nz_reg   <= sup_nz;
        for (int s = 0; s < NS; s++) begin
            s2_idx_reg[s] <= sup_idx[s];
        end
    end

    assign find.valid = s2_valid_reg;
    assign find.hit   = hit;
    assign find.last  = s2_last_reg;
    assign hit_addr   = s2_addr_reg;
    assign hit_bit    = bit_sel;
    assign hit_word   = s2_word_reg;

endmodule

FILE: rtl/core/block_bitmap_allocator_top.sv
// Block bitmap allocator top level: request sequencer, region registers, result register.
//
// Keeps one bit per block (1 = free) in a memory of BLOCK_COUNT/256 words of 256 bits
// (64-bit words below 256 blocks), one read and one write port, registered read.
// After reset a clearing pass writes the initial map, one word a cycle; no request is
// taken until it is done, configuration writes are taken at any time. An allocate
// streams the words from the one holding the first block of the region to the one
// holding its last block through a pipelined finder, and reports full without reading
// when the region is empty. A free reads the word, checks the bit, writes it back set
// unless it was already free and registers the result, or reports a range error when
// the block lies outside the region. The next request is taken while a finished result
// still waits in the output register.
module block_bitmap_allocator_top import bba_pkg::*; #(
    parameter int BLOCK_COUNT = 4096
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [15:0]          s_tdata,   // [11:0] block_number, [15:12] zero
    input  logic [0:0]           s_tuser,   // [0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [11:0] allocated_block, [15:12] zero
    output logic [1:0]           m_tuser    // [1:0] status
);

    localparam int WB    = (BLOCK_COUNT >= 256) ? 256 : 64;
    localparam int WBB   = $clog2(WB);
    localparam int WORDS = (BLOCK_COUNT + WB - 1) / WB;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int RW    = ($clog2(BLOCK_COUNT + 1) > REG_W) ? $clog2(BLOCK_COUNT + 1)
                                                             : REG_W;
    localparam int GW    = AW + WBB;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SCAN     = 3'd1;
    localparam logic [2:0] S_ALLOC_WR = 3'd2;
    localparam logic [2:0] S_FREE_RD  = 3'd3;
    localparam logic [2:0] S_FREE_CHK = 3'd4;
    localparam logic [2:0] S_EMIT     = 3'd5;

    logic [2:0] state_reg, state_next;

    logic [REG_W-1:0] first_reg, limit_reg;

    // region values derived from the registers, updated in the cycle after they change
    logic [RW-1:0] end_v, end_m1, first_ext;
    logic [RW-1:0] rgn_first_reg, rgn_end_reg;
    logic          rgn_empty_reg;
    logic [AW-1:0] rgn_start_reg, rgn_last_reg;
    logic [WB-1:0] rgn_lo_reg, rgn_hi_reg;

    logic [BLK_W-1:0] blk_reg, blk_next;
    logic [AW-1:0]    issue_addr_reg, issue_addr_next;
    logic             issue_live_reg, issue_live_next;
    logic [AW-1:0]    hit_addr_reg;
    logic [WBB-1:0]   hit_bit_reg;
    logic [WB-1:0]    hit_word_reg;
    logic [1:0]       res_status_reg, res_status_next;
    logic [BLK_W-1:0] res_block_reg, res_block_next;

    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic [BLK_W-1:0] m_block_reg;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    logic [WB-1:0] wr_data;
    logic          st_rd_valid;
    logic [AW-1:0] st_rd_addr;
    logic [WB-1:0] st_rd_data;
    logic          init_busy;

    bba_find_t      f_stat;
    logic [AW-1:0]  f_hit_addr;
    logic [WBB-1:0] f_hit_bit;
    logic [WB-1:0]  f_hit_word;
    logic           f_flush;
    logic           scan_stop;

    logic           accept;
    logic           out_free;
    logic [RW-1:0]  blk_ext;
    logic           blk_in_region;
    logic [AW-1:0]  blk_word;
    logic [WBB-1:0] blk_bit;
    logic [WB-1:0]  blk_onehot;
    logic [GW-1:0]  granted;

    bba_bitmap_store #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .WB(WB),
        .AW(AW)
    ) u_store (
        .aclk(aclk),
        .aresetn(aresetn),
        .rd_en(rd_en),
        .rd_addr(rd_addr),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_valid(st_rd_valid),
        .rd_addr_q(st_rd_addr),
        .rd_data(st_rd_data),
        .init_busy(init_busy)
    );

    bba_first_free #(
        .WB(WB),
        .AW(AW)
    ) u_find (
        .aclk(aclk),
        .aresetn(aresetn),
        .flush(f_flush),
        .in_valid(st_rd_valid && (state_reg == S_SCAN)),
        .in_addr(st_rd_addr),
        .in_data(st_rd_data),
        .start_word(rgn_start_reg),
        .last_word(rgn_last_reg),
        .lo_mask(rgn_lo_reg),
        .hi_mask(rgn_hi_reg),
        .find(f_stat),
        .hit_addr(f_hit_addr),
        .hit_bit(f_hit_bit),
        .hit_word(f_hit_word)
    );

    // region end capped at the volume size
    always_comb begin
        first_ext = RW'(first_reg);
        end_v     = (RW'(limit_reg) > RW'(BLOCK_COUNT)) ? RW'(BLOCK_COUNT) : RW'(limit_reg);
        end_m1    = end_v - RW'(1);
    end

    always_ff @(posedge aclk) begin
        rgn_first_reg <= first_ext;
        rgn_end_reg   <= end_v;
        rgn_empty_reg <= (first_ext >= end_v);
        rgn_start_reg <= AW'(first_ext >> WBB);
        rgn_last_reg  <= AW'(end_m1 >> WBB);
        rgn_lo_reg    <= {WB{1'b1}} << first_ext[WBB-1:0];
        rgn_hi_reg    <= {WB{1'b1}} >> (WBB'(WB - 1) - end_m1[WBB-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= FIRST_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FIRST: first_reg <= cfg_data;
                CFG_LIMIT: limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    assign s_tready  = (state_reg == S_IDLE) && !init_busy;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign scan_stop = f_stat.valid && (f_stat.hit || f_stat.last);
    assign f_flush   = (state_reg != S_SCAN) || scan_stop;

    assign blk_ext       = RW'(blk_reg);
    assign blk_in_region = (blk_ext >= rgn_first_reg) && (blk_ext < rgn_end_reg);
    assign blk_word      = AW'(blk_ext >> WBB);
    assign blk_bit       = blk_reg[WBB-1:0];
    assign blk_onehot    = WB'(1) << blk_bit;
    assign granted       = {hit_addr_reg, hit_bit_reg};

    always_comb begin
        state_next      = state_reg;
        blk_next        = blk_reg;
        issue_addr_next = issue_addr_reg;
        issue_live_next = issue_live_reg;
        res_status_next = res_status_reg;
        res_block_next  = res_block_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = hit_addr_reg;
        wr_data         = hit_word_reg & ~(WB'(1) << hit_bit_reg);
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // taken from the live registers: a write may have just landed
                    blk_next        = s_tdata[BLK_W-1:0];
                    issue_addr_next = AW'(first_ext >> WBB);
                    issue_live_next = (first_ext < end_v);
                    state_next      = (s_tuser[0] == MODE_FREE) ? S_FREE_RD : S_SCAN;
                end
            end
            S_SCAN: begin
                if (issue_live_reg && !scan_stop) begin
                    rd_en           = 1'b1;
                    issue_addr_next = issue_addr_reg + AW'(1);
                    if (issue_addr_reg == rgn_last_reg) begin
                        issue_live_next = 1'b0;
                    end
                end
                if (rgn_empty_reg) begin
                    res_status_next = ST_FULL;
                    res_block_next  = '0;
                    state_next      = S_EMIT;
                end else if (f_stat.valid && f_stat.hit) begin
                    state_next = S_ALLOC_WR;
                end else if (f_stat.valid && f_stat.last) begin
                    res_status_next = ST_FULL;
                    res_block_next  = '0;
                    state_next      = S_EMIT;
                end
            end
            S_ALLOC_WR: begin
                wr_en           = 1'b1;
                res_status_next = ST_OK;
                res_block_next  = BLK_W'(granted);
                state_next      = S_EMIT;
            end
            S_FREE_RD: begin
                if (blk_in_region) begin
                    rd_en      = 1'b1;
                    rd_addr    = blk_word;
                    state_next = S_FREE_CHK;
                end else begin
                    res_status_next = ST_RANGE;
                    res_block_next  = '0;
                    state_next      = S_EMIT;
                end
            end
            S_FREE_CHK: begin
                res_block_next = '0;
                wr_addr        = blk_word;
                wr_data        = st_rd_data | blk_onehot;
                if (st_rd_data[blk_bit]) begin
                    res_status_next = ST_ALREADY_FREE;
                end else begin
                    wr_en           = 1'b1;
                    res_status_next = ST_OK;
                end
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issue_live_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            issue_live_reg <= issue_live_next;
            if ((state_reg == S_EMIT) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        blk_reg        <= blk_next;
        issue_addr_reg <= issue_addr_next;
        res_status_reg <= res_status_next;
        res_block_reg  <= res_block_next;
        if ((state_reg == S_SCAN) && f_stat.valid && f_stat.hit) begin
            hit_addr_reg <= f_hit_addr;
            hit_bit_reg  <= f_hit_bit;
            hit_word_reg <= f_hit_word;
        end
        if ((state_reg == S_EMIT) && out_free) begin
            m_status_reg <= res_status_reg;
            m_block_reg  <= res_block_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_block_reg};
    assign m_tuser  = m_status_reg;

endmodule
